### hw/rtl/sfla_pkg.sv
// Shared types and constants for the slot free-list allocator.
`default_nettype none

package sfla_pkg;

    localparam int unsigned SLOTS   = 256;
    localparam int unsigned IDX_W   = $clog2(SLOTS);
    localparam int unsigned CNT_W   = $clog2(SLOTS + 1);

    // fixed field widths of the beats
    localparam int unsigned SLOT_IN_W = 12;
    localparam int unsigned GRANT_W   = 8;
    localparam int unsigned TOTAL_W   = 9;

    typedef enum logic [1:0] {
        MODE_ALLOC   = 2'd0,
        MODE_RELEASE = 2'd1,
        MODE_CLEAR   = 2'd2,
        MODE_COMPACT = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STAT_DONE    = 2'd0,
        STAT_FULL    = 2'd1,
        STAT_IGNORED = 2'd2
    } status_t;

    typedef struct packed {
        mode_t                  mode;
        logic [SLOT_IN_W-1:0]   slot_index;
    } in_beat_t;

    typedef struct packed {
        logic [GRANT_W-1:0]     granted_index;
        status_t                status;
        logic [TOTAL_W-1:0]     live_total;
    } out_beat_t;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_ALLOC,
        S_RELEASE,
        S_CLEAR,
        S_COUNT,
        S_PACK,
        S_RESP
    } fsm_t;

endpackage

`default_nettype wire

### hw/rtl/sfla_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
`default_nettype none

module sfla_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read data holds when no read is issued
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### hw/rtl/slot_free_list_allocator_top.sv
// Top level of the slot free-list allocator: control sequencer and state memories.
`default_nettype none

// Hands out slot indices from a stack of free indices kept in a RAM, with the
// per-slot live bits in a second RAM. Every input beat yields exactly one
// output beat. After reset the block runs a fill pass over all SLOTS slots
// that loads the stack (highest index at the bottom, zero on top) and clears
// the live bits; in_stall stays high through it. One beat is worked at a
// time: allocate and release go through accept, RAM read and result; clear
// does one RAM write per slot and compact makes one pass reading the
// live-bit RAM to count and one pass rewriting both RAMs. The passes follow
// from the single read and write port of each RAM. A finished result sits
// in the output register until taken; a new beat is accepted meanwhile, and
// its result waits for that register to drain. Allocate on an empty stack
// returns status 1; release of an out-of-range or free slot returns status 2
// and changes nothing.

module slot_free_list_allocator_top
    import sfla_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    input  wire in_beat_t  in_data,
    output logic           out_valid,
    input  wire logic      out_stall,
    output out_beat_t      out_data
);

    localparam logic [CNT_W-1:0] LAST_SLOT = CNT_W'(SLOTS - 1);
    localparam logic [CNT_W-1:0] SLOT_CNT  = CNT_W'(SLOTS);

    // control state
    fsm_t             state_reg,  state_next;
    logic [CNT_W-1:0] depth_reg,  depth_next;    // entries on the free stack
    logic [CNT_W-1:0] count_reg,  count_next;    // live slots
    logic [CNT_W-1:0] scan_reg,   scan_next;     // slot walker for passes
    logic [CNT_W-1:0] packed_reg, packed_next;   // live slots seen by compact
    logic             out_valid_reg, out_valid_next;

    // per-beat payload
    logic [IDX_W-1:0] idx_reg,     idx_next;
    logic             inrange_reg, inrange_next;
    logic             empty_reg,   empty_next;
    logic [GRANT_W-1:0] res_grant_reg, res_grant_next;
    status_t          res_status_reg, res_status_next;
    out_beat_t        out_data_reg, out_data_next;

    // RAM ports
    logic             stk_we, stk_re;
    logic [IDX_W-1:0] stk_waddr, stk_raddr, stk_wdata, stk_rdata;
    logic             live_we, live_re;
    logic [IDX_W-1:0] live_waddr, live_raddr;
    logic [0:0]       live_wdata, live_rdata;

    logic             can_load;
    logic [CNT_W-1:0] depth_m1;
    logic [CNT_W-1:0] pack_off;

    sfla_ram #(.WIDTH(IDX_W), .DEPTH(SLOTS)) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (stk_re),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    sfla_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_live_ram (
        .clk   (clk),
        .we    (live_we),
        .waddr (live_waddr),
        .wdata (live_wdata),
        .re    (live_re),
        .raddr (live_raddr),
        .rdata (live_rdata)
    );

    assign can_load  = !out_valid_reg || !out_stall;
    assign depth_m1  = depth_reg - CNT_W'(1);
    assign pack_off  = scan_reg - packed_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        state_next      = state_reg;
        depth_next      = depth_reg;
        count_next      = count_reg;
        scan_next       = scan_reg;
        packed_next     = packed_reg;
        idx_next        = idx_reg;
        inrange_next    = inrange_reg;
        empty_next      = empty_reg;
        res_grant_next  = res_grant_reg;
        res_status_next = res_status_reg;
        in_stall        = 1'b1;

        stk_we     = 1'b0;
        stk_waddr  = '0;
        stk_wdata  = '0;
        stk_re     = 1'b0;
        stk_raddr  = '0;
        live_we    = 1'b0;
        live_waddr = '0;
        live_wdata = '0;
        live_re    = 1'b0;
        live_raddr = '0;

        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;

        unique case (state_reg)
            // fill pass after reset: stack holds SLOTS-1 .. 0, zero on top
            S_INIT:
            begin
                stk_we     = 1'b1;
                stk_waddr  = scan_reg[IDX_W-1:0];
                stk_wdata  = IDX_W'(SLOTS - 1) - scan_reg[IDX_W-1:0];
                live_we    = 1'b1;
                live_waddr = scan_reg[IDX_W-1:0];
                live_wdata = 1'b0;
                if (scan_reg == LAST_SLOT)
                begin
                    scan_next  = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    scan_next = scan_reg + CNT_W'(1);
                end
            end

            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    unique case (in_data.mode)
                        MODE_ALLOC:
                        begin
                            empty_next = (depth_reg == '0);
                            stk_re     = (depth_reg != '0);
                            stk_raddr  = depth_m1[IDX_W-1:0];
                            state_next = S_ALLOC;
                        end
                        MODE_RELEASE:
                        begin
                            inrange_next = ({1'b0, in_data.slot_index}
                                            < (SLOT_IN_W + 1)'(SLOTS));
                            idx_next     = in_data.slot_index[IDX_W-1:0];
                            live_re      = 1'b1;
                            live_raddr   = in_data.slot_index[IDX_W-1:0];
                            state_next   = S_RELEASE;
                        end
                        MODE_CLEAR:
                        begin
                            scan_next  = '0;
                            state_next = S_CLEAR;
                        end
                        MODE_COMPACT:
                        begin
                            live_re     = 1'b1;
                            live_raddr  = '0;
                            scan_next   = CNT_W'(1);
                            packed_next = '0;
                            state_next  = S_COUNT;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // top of stack arrives from the RAM
            S_ALLOC:
            begin
                res_grant_next = '0;
                if (empty_reg)
                begin
                    res_status_next = STAT_FULL;
                end
                else
                begin
                    live_we         = 1'b1;
                    live_waddr      = stk_rdata;
                    live_wdata      = 1'b1;
                    depth_next      = depth_m1;
                    if (count_reg < SLOT_CNT)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    res_grant_next  = GRANT_W'(stk_rdata);
                    res_status_next = STAT_DONE;
                end
                state_next = S_RESP;
            end

            // live bit of the requested slot arrives from the RAM
            S_RELEASE:
            begin
                res_grant_next = '0;
                if (inrange_reg && live_rdata[0])
                begin
                    live_we    = 1'b1;
                    live_waddr = idx_reg;
                    live_wdata = 1'b0;
                    if (depth_reg < SLOT_CNT)
                    begin
                        stk_we     = 1'b1;
                        stk_waddr  = depth_reg[IDX_W-1:0];
                        stk_wdata  = idx_reg;
                        depth_next = depth_reg + CNT_W'(1);
                    end
                    if (count_reg != '0)
                    begin
                        count_next = count_reg - CNT_W'(1);
                    end
                    res_status_next = STAT_DONE;
                end
                else
                begin
                    res_status_next = STAT_IGNORED;
                end
                state_next = S_RESP;
            end

            // ascending refill, highest index on top
            S_CLEAR:
            begin
                stk_we     = 1'b1;
                stk_waddr  = scan_reg[IDX_W-1:0];
                stk_wdata  = scan_reg[IDX_W-1:0];
                live_we    = 1'b1;
                live_waddr = scan_reg[IDX_W-1:0];
                live_wdata = 1'b0;
                if (scan_reg == LAST_SLOT)
                begin
                    scan_next       = '0;
                    depth_next      = SLOT_CNT;
                    count_next      = '0;
                    res_grant_next  = '0;
                    res_status_next = STAT_DONE;
                    state_next      = S_RESP;
                end
                else
                begin
                    scan_next = scan_reg + CNT_W'(1);
                end
            end

            // read data arrives the cycle after its address is issued
            S_COUNT:
            begin
                packed_next = packed_reg + CNT_W'(live_rdata);
                if (scan_reg == SLOT_CNT)
                begin
                    scan_next  = '0;
                    state_next = S_PACK;
                end
                else
                begin
                    live_re    = 1'b1;
                    live_raddr = scan_reg[IDX_W-1:0];
                    scan_next  = scan_reg + CNT_W'(1);
                end
            end

            S_PACK:
            begin
                live_we    = 1'b1;
                live_waddr = scan_reg[IDX_W-1:0];
                live_wdata = (scan_reg < packed_reg);
                if (scan_reg >= packed_reg)
                begin
                    stk_we    = 1'b1;
                    stk_waddr = pack_off[IDX_W-1:0];
                    stk_wdata = scan_reg[IDX_W-1:0];
                end
                if (scan_reg == LAST_SLOT)
                begin
                    scan_next       = '0;
                    depth_next      = SLOT_CNT - packed_reg;
                    count_next      = packed_reg;
                    res_grant_next  = '0;
                    res_status_next = STAT_DONE;
                    state_next      = S_RESP;
                end
                else
                begin
                    scan_next = scan_reg + CNT_W'(1);
                end
            end

            // wait for the output register to drain
            S_RESP:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '{granted_index: res_grant_reg,
                                       status:        res_status_reg,
                                       live_total:    TOTAL_W'(count_reg)};
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            depth_reg     <= SLOT_CNT;
            count_reg     <= '0;
            scan_reg      <= '0;
            packed_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            count_reg     <= count_next;
            scan_reg      <= scan_next;
            packed_reg    <= packed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        inrange_reg    <= inrange_next;
        empty_reg      <= empty_next;
        res_grant_reg  <= res_grant_next;
        res_status_reg <= res_status_next;
        out_data_reg   <= out_data_next;
    end

    // every slot is either live or on the free stack between beats
    a_depth_count_sum: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> ({1'b0, depth_reg} + {1'b0, count_reg}) == (CNT_W + 1)'(SLOTS))
        else $error("free stack depth and live count disagree");

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= SLOT_CNT)
        else $error("free stack overflow");

    a_beat_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_stall) ##1 out_valid_reg |-> $past(state_reg) == S_RESP)
        else $error("output beat loaded outside the result state");

    a_full_only_empty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ALLOC && !empty_reg |=> res_status_reg == STAT_DONE)
        else $error("allocate from a nonempty stack reported full");

endmodule

`default_nettype wire
